@@ rtl/core/orel_pkg.sv @@
`default_nettype none
package orel_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CapW     = 5;
  localparam int unsigned CapMin   = 2;
  localparam int unsigned CapReset = 16;
  localparam int unsigned RegIdxW  = 1;

  localparam logic [RegIdxW-1:0] REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_VALUE  = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_HIDDEN = 2'd2
  } status_e;

  typedef struct packed {
    logic wr;
    logic rd_head;
    logic rd_ptr;
    logic pop;
    logic load_ptr;
    logic emit;
    logic emit_empty;
    logic emit_hide;
    logic emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic head_last;
    logic ptr_last;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/overwrite_ring_event_log.sv @@
// Ring event log that keeps up to capacity-1 entries and drops the oldest when full.
// Command channel: an item (cmd_i, value_i) is taken at a rising edge with start high
// and busy low. Add stores value_i and gives no result. Remove gives one result with
// the oldest entry, an empty status, or a hidden status for a stored -1. List gives
// every held entry oldest first, last_o marking the final one, or one empty status.
// Result channel: done_o marks a beat of status_o, entry_o and last_o for one cycle;
// the receiver cannot hold it off, and every beat is taken at the end of that cycle.
// A result appears the cycle after its command is taken (registered read of
// the entry memory). Add and remove may come every cycle while busy is low.
// List holds busy high while it walks the ring, one memory read and one beat per
// cycle, and no new command is taken until its final entry has been read.
// Configuration: capacity at byte address 0 over the APB port; a write empties the log.
// Write only while the log is idle. Values below 2 act as 2, above DEPTH as DEPTH.
// Reset: head and tail return to zero (empty log) and capacity to 16; entry memory is
// not cleared and needs no clearing pass.
`default_nettype none
module overwrite_ring_event_log #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [orel_pkg::DataW-1:0]    value_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [orel_pkg::DataW-1:0]         entry_o,
  output logic                               last_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [orel_pkg::CapW-1:0] cap_q;
  logic                      reg_sel, cfg_wr;
  orel_pkg::dp_cmd_t         dp_cmd;
  orel_pkg::dp_stat_t        dp_stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2 +: orel_pkg::RegIdxW] == orel_pkg::REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= orel_pkg::CapW'(orel_pkg::CapReset);
    end else if (cfg_wr) begin
      cap_q <= pwdata[orel_pkg::CapW-1:0];
    end
  end

  orel_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .stat_i   (dp_stat),
    .dp_cmd_o (dp_cmd),
    .busy     (busy)
  );

  orel_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dp_cmd_i  (dp_cmd),
    .value_i   (value_i),
    .cap_i     (cap_q),
    .cfg_clr_i (cfg_wr),
    .stat_o    (dp_stat),
    .done_o    (done_o),
    .status_o  (status_o),
    .entry_o   (entry_o),
    .last_o    (last_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/orel_ctrl.sv @@
`default_nettype none
module orel_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic [1:0]         cmd_i,
  input  orel_pkg::dp_stat_t      stat_i,
  output orel_pkg::dp_cmd_t       dp_cmd_o,
  output logic                    busy
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state_q, state_d;
  orel_pkg::cmd_e cmd;

  assign cmd  = orel_pkg::cmd_e'(cmd_i);
  assign busy = (state_q == S_LIST);

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd)
            orel_pkg::CMD_ADD: begin
              dp_cmd_o.wr = 1'b1;
            end
            orel_pkg::CMD_REMOVE: begin
              dp_cmd_o.emit      = 1'b1;
              dp_cmd_o.emit_last = 1'b1;
              if (stat_i.empty) begin
                dp_cmd_o.emit_empty = 1'b1;
              end else begin
                dp_cmd_o.rd_head   = 1'b1;
                dp_cmd_o.pop       = 1'b1;
                dp_cmd_o.emit_hide = 1'b1;
              end
            end
            orel_pkg::CMD_LIST: begin
              dp_cmd_o.emit = 1'b1;
              if (stat_i.empty) begin
                dp_cmd_o.emit_empty = 1'b1;
                dp_cmd_o.emit_last  = 1'b1;
              end else begin
                dp_cmd_o.rd_head   = 1'b1;
                dp_cmd_o.load_ptr  = 1'b1;
                dp_cmd_o.emit_last = stat_i.head_last;
                if (!stat_i.head_last) begin
                  state_d = S_LIST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        dp_cmd_o.rd_ptr    = 1'b1;
        dp_cmd_o.emit      = 1'b1;
        dp_cmd_o.emit_last = stat_i.ptr_last;
        if (stat_i.ptr_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/orel_dp.sv @@
`default_nettype none
module orel_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  orel_pkg::dp_cmd_t                  dp_cmd_i,
  input  wire logic [orel_pkg::DataW-1:0]    value_i,
  input  wire logic [orel_pkg::CapW-1:0]     cap_i,
  input  wire logic                          cfg_clr_i,
  output orel_pkg::dp_stat_t                 stat_o,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [orel_pkg::DataW-1:0]         entry_o,
  output logic                               last_o
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned DW  = $clog2(DEPTH + 1);
  localparam int unsigned EW  = (DW > orel_pkg::CapW) ? DW : orel_pkg::CapW;
  localparam logic [EW-1:0] CAP_LO = EW'(orel_pkg::CapMin);
  localparam logic [EW-1:0] CAP_HI = EW'(DEPTH);

  logic [orel_pkg::DataW-1:0] mem [DEPTH];
  logic [orel_pkg::DataW-1:0] rdata_q;
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d, raddr;
  logic [IW-1:0] head_nx, tail_nx, ptr_nx;
  logic [EW-1:0] cap_ext, ecap;
  logic done_q, empty_q, hide_q, last_q;
  orel_pkg::status_e status;

  always_comb begin
    cap_ext = EW'(cap_i);
    if (cap_ext < CAP_LO) begin
      ecap = CAP_LO;
    end else if (cap_ext > CAP_HI) begin
      ecap = CAP_HI;
    end else begin
      ecap = cap_ext;
    end
  end

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i, input logic [EW-1:0] k);
    logic [EW-1:0] s;
    s = EW'(i) + EW'(1);
    return (s >= k) ? '0 : s[IW-1:0];
  endfunction

  assign head_nx = next_idx(head_q, ecap);
  assign tail_nx = next_idx(tail_q, ecap);
  assign ptr_nx  = next_idx(ptr_q, ecap);

  assign stat_o.empty     = (head_q == tail_q);
  assign stat_o.head_last = (head_nx == tail_q);
  assign stat_o.ptr_last  = (ptr_nx == tail_q);

  assign raddr = dp_cmd_i.rd_head ? head_q : ptr_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    ptr_d  = ptr_q;
    if (cfg_clr_i) begin
      head_d = '0;
      tail_d = '0;
    end else if (dp_cmd_i.wr) begin
      tail_d = tail_nx;
      if (tail_nx == head_q) begin
        head_d = head_nx;
      end
    end else if (dp_cmd_i.pop) begin
      head_d = head_nx;
    end
    if (dp_cmd_i.load_ptr) begin
      ptr_d = head_nx;
    end else if (dp_cmd_i.rd_ptr) begin
      ptr_d = ptr_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.wr) begin
      mem[tail_q] <= value_i;
    end
    if (dp_cmd_i.rd_head || dp_cmd_i.rd_ptr) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      ptr_q   <= '0;
      done_q  <= 1'b0;
      empty_q <= 1'b0;
      hide_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      ptr_q   <= ptr_d;
      done_q  <= dp_cmd_i.emit;
      empty_q <= dp_cmd_i.emit_empty;
      hide_q  <= dp_cmd_i.emit_hide;
      last_q  <= dp_cmd_i.emit_last;
    end
  end

  always_comb begin
    if (empty_q) begin
      status = orel_pkg::ST_EMPTY;
    end else if (hide_q && (rdata_q == '1)) begin
      status = orel_pkg::ST_HIDDEN;
    end else begin
      status = orel_pkg::ST_VALUE;
    end
  end

  assign done_o   = done_q;
  assign status_o = status;
  assign entry_o  = (status == orel_pkg::ST_VALUE) ? rdata_q : '0;
  assign last_o   = last_q;

endmodule
`default_nettype wire

@@ rtl/core/orel_checker.sv @@
`default_nettype none
module orel_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  cmd_i,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic        last_o
);

  logic take;
  assign take = start && !busy;

  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (cmd_i == orel_pkg::CMD_ADD) |=> !done_o)
    else $error("add produced a result beat");

  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (cmd_i == orel_pkg::CMD_REMOVE) |=> done_o && last_o)
    else $error("remove did not give a single final beat");

  a_list_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |=> done_o)
    else $error("list stream broke before its final beat");

  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != orel_pkg::ST_VALUE) |-> last_o)
    else $error("non-value status on a non-final beat");

  a_busy_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> done_o && !last_o)
    else $error("busy without a list beat in flight");

endmodule

bind overwrite_ring_event_log orel_checker u_orel_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .status_o (status_o),
  .last_o   (last_o)
);
`default_nettype wire

@@ bench/overwrite_ring_event_log_check.sv @@
module overwrite_ring_event_log_check
  import orel_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [DataW-1:0]  value_i,
  input  logic              done_o,
  input  logic [1:0]        status_o,
  input  logic [DataW-1:0]  entry_o,
  input  logic              last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                beat_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] entry;
    logic             last;
  } beat_t;

  logic [DataW-1:0] ring [DEPTH];
  int unsigned      head_q;
  int unsigned      tail_q;
  logic [CapW-1:0]  cap_reg;
  beat_t            due_beats [$];

  function automatic int unsigned ring_span();
    int unsigned k;
    k = cap_reg;
    if (k < CapMin) k = CapMin;
    if (k > DEPTH) k = DEPTH;
    return k;
  endfunction

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= ring_span()) ? 0 : i + 1;
  endfunction

  function automatic beat_t mk_beat(status_e s, logic [DataW-1:0] e, logic l);
    beat_t b;
    b.status = s;
    b.entry  = e;
    b.last   = l;
    return b;
  endfunction

  task automatic log_apply(input logic [1:0] c, input logic [DataW-1:0] v);
    int unsigned      i;
    int unsigned      nx;
    int unsigned      n;
    logic [DataW-1:0] x;
    case (c)
      CMD_ADD: begin
        if (ring_next(tail_q) == head_q) head_q = ring_next(head_q);
        ring[tail_q] = v;
        tail_q = ring_next(tail_q);
      end
      CMD_REMOVE: begin
        if (head_q == tail_q) begin
          due_beats.push_back(mk_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          x = ring[head_q];
          head_q = ring_next(head_q);
          if (x == '1) due_beats.push_back(mk_beat(ST_HIDDEN, '0, 1'b1));
          else due_beats.push_back(mk_beat(ST_VALUE, x, 1'b1));
        end
      end
      CMD_LIST: begin
        if (head_q == tail_q) begin
          due_beats.push_back(mk_beat(ST_EMPTY, '0, 1'b1));
        end else begin
          i = head_q;
          n = 0;
          while (i != tail_q && n < DEPTH - 1) begin
            nx = ring_next(i);
            due_beats.push_back(mk_beat(ST_VALUE, ring[i], nx == tail_q));
            i = nx;
            n++;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t b;
    if (!rst_ni) begin
      head_q     = 0;
      tail_q     = 0;
      cap_reg    = CapW'(CapReset);
      fail_count = 0;
      beat_count = 0;
      due_beats.delete();
    end else begin
      if (psel && penable && pready && paddr == {REG_CAPACITY, 2'b00}) begin
        if (pwrite) begin
          cap_reg = pwdata[CapW-1:0];
          head_q  = 0;
          tail_q  = 0;
        end else if (prdata != 32'(cap_reg)) begin
          $display("%0t: capacity read expected %0d actual %0d", $time, cap_reg, prdata);
          fail_count++;
        end
      end
      if (start && !busy) log_apply(cmd_i, value_i);
      if (done_o) begin
        beat_count++;
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat status %0d entry %0h last %0b", $time,
                   status_o, entry_o, last_o);
          fail_count++;
        end else begin
          b = due_beats.pop_front();
          if (status_o != b.status) begin
            $display("%0t: status expected %0d actual %0d", $time, b.status, status_o);
            fail_count++;
          end
          if (entry_o != b.entry) begin
            $display("%0t: entry expected %0h actual %0h", $time, b.entry, entry_o);
            fail_count++;
          end
          if (last_o != b.last) begin
            $display("%0t: last expected %0b actual %0b", $time, b.last, last_o);
            fail_count++;
          end
        end
      end
    end
    pending = due_beats.size();
  end

endmodule

@@ bench/tb.sv @@
module tb;
  import orel_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  logic [1:0]        cmd_i   = '0;
  logic [DataW-1:0]  value_i = '0;
  logic              done_o;
  logic [1:0]        status_o;
  logic [DataW-1:0]  entry_o;
  logic              last_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int beat_count;
  int idle_max;
  int cmd_count;
  int setting_count;

  always #1ns clk_i = ~clk_i;

  overwrite_ring_event_log #(.DEPTH(16)) DUT (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .value_i,
    .done_o, .status_o, .entry_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  overwrite_ring_event_log_check #(.DEPTH(16)) u_check (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .value_i,
    .done_o, .status_o, .entry_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending, .beat_count
  );

  task automatic issue_cmd(input logic [1:0] c, input logic [DataW-1:0] v);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    cmd_i   <= c;
    value_i <= v;
    do @(posedge clk_i); while (!(start && !busy));
    if (c != CMD_UNUSED) cmd_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int          caps [10];
    int          add_pct;
    int          r;
    int          n;
    logic [31:0] w;
    caps = '{2, 3, 0, 1, 17, 31, 16, 5, 16, 9};
    caps[9] = $urandom_range(CapMin, 16);
    idle_max = 6;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_cmd(CMD_REMOVE, '0);
    issue_cmd(CMD_LIST, '1);
    issue_cmd(CMD_UNUSED, 32'hA5A5_5A5A);
    issue_cmd(CMD_ADD, 32'h7FFF_FFFF);
    issue_cmd(CMD_ADD, 32'h8000_0000);
    issue_cmd(CMD_ADD, '1);
    issue_cmd(CMD_ADD, '0);
    issue_cmd(CMD_LIST, '0);
    issue_cmd(CMD_REMOVE, '0);
    issue_cmd(CMD_REMOVE, '1);
    issue_cmd(CMD_REMOVE, '0);
    issue_cmd(CMD_REMOVE, '0);
    issue_cmd(CMD_REMOVE, '0);
    issue_cmd(CMD_ADD, 32'h1234_5678);
    issue_cmd(CMD_LIST, '0);
    drain();

    for (int p = 0; p < 10; p++) begin
      w = $urandom();
      w[CapW-1:0] = CapW'(caps[p]);
      apb_access(1'b1, w);
      apb_access(1'b0, '0);
      setting_count++;
      idle_max = (p % 3 == 2) ? 0 : 6;
      add_pct = (caps[p] >= 16) ? 72 : 55;
      n = 0;
      while (n < 28) begin
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
          issue_cmd(CMD_ADD, pick_value());
          n++;
        end else if (r < add_pct + (95 - add_pct) * 6 / 10) begin
          issue_cmd(CMD_REMOVE, $urandom());
          n++;
        end else if (r < 95) begin
          issue_cmd(CMD_LIST, $urandom());
          n++;
        end else begin
          issue_cmd(CMD_UNUSED, $urandom());
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("Ran %0d commands over %0d capacity settings, %0d result beats checked.",
             cmd_count, setting_count, beat_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** overwrite_ring_event_log: PASSED **");
    end else begin
      $display("Failures: %0d, beats still expected: %0d", fail_count, pending);
      $display("** overwrite_ring_event_log: FAILED **");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("Timeout with %0d beats still expected", pending);
    $display("** overwrite_ring_event_log: FAILED **");
    $finish;
  end

endmodule
